[src/omni_wheel_accel_limiter_macros.svh]
// Assertion macros shared by the omni-wheel limiter RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef OMNI_WHEEL_ACCEL_LIMITER_MACROS_SVH
`define OMNI_WHEEL_ACCEL_LIMITER_MACROS_SVH

// same-cycle implication
`define OWAL_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("owal: same-cycle check failed");

// next-cycle implication
`define OWAL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("owal: next-cycle check failed");

`endif

[src/owal_pkg.sv]
// Package for the omni-wheel limiter: datapath op codes, command/status
// structs, fixed-point constants and rounding/saturation helpers. No deps.
package owal_pkg;

  // config register indexes
  localparam logic [1:0] REG_ACCEL_THR = 2'd0;
  localparam logic [1:0] REG_CONV_EN   = 2'd1;

  // fixed-point constants (Q16 / Q24 scaled)
  localparam logic signed [26:0] K_DIAG  = 27'sd46334;
  localparam logic signed [26:0] K_DIST  = 27'sd1330381;
  localparam logic signed [26:0] K_INV_W = 27'sd206616;
  localparam logic signed [26:0] K_INV_V = 27'sd5932537;
  localparam logic [30:0]        CENT_K  = 31'd25600;
  localparam logic [25:0]        CONV_DIV = 26'd2560;
  localparam logic [5:0]         SH_WHEEL = 6'd16;
  localparam logic [5:0]         SH_BODY  = 6'd24;

  // datapath ops
  localparam logic [5:0] OP_NOP   = 6'd0;
  localparam logic [5:0] OP_LOAD  = 6'd1;
  localparam logic [5:0] OP_RMUL  = 6'd2;
  localparam logic [5:0] OP_WMUL  = 6'd3;
  localparam logic [5:0] OP_WFIN  = 6'd4;
  localparam logic [5:0] OP_ACC   = 6'd5;
  localparam logic [5:0] OP_CMP1  = 6'd6;
  localparam logic [5:0] OP_CMP2  = 6'd7;
  localparam logic [5:0] OP_CMP3  = 6'd8;
  localparam logic [5:0] OP_SMUL  = 6'd9;
  localparam logic [5:0] OP_SDIV  = 6'd10;
  localparam logic [5:0] OP_SFIN  = 6'd11;
  localparam logic [5:0] OP_BSUM  = 6'd12;
  localparam logic [5:0] OP_B1    = 6'd13;
  localparam logic [5:0] OP_B2    = 6'd14;
  localparam logic [5:0] OP_B3    = 6'd15;
  localparam logic [5:0] OP_B4    = 6'd16;
  localparam logic [5:0] OP_C1    = 6'd17;
  localparam logic [5:0] OP_C2    = 6'd18;
  localparam logic [5:0] OP_C3    = 6'd19;
  localparam logic [5:0] OP_SQ    = 6'd20;
  localparam logic [5:0] OP_C4    = 6'd21;
  localparam logic [5:0] OP_C5    = 6'd22;
  localparam logic [5:0] OP_C6    = 6'd23;
  localparam logic [5:0] OP_C7    = 6'd24;
  localparam logic [5:0] OP_KMUL  = 6'd25;
  localparam logic [5:0] OP_KDIV  = 6'd26;
  localparam logic [5:0] OP_KFIN  = 6'd27;
  localparam logic [5:0] OP_STORE = 6'd28;
  localparam logic [5:0] OP_V1    = 6'd29;
  localparam logic [5:0] OP_V2    = 6'd30;
  localparam logic [5:0] OP_V3    = 6'd31;
  localparam logic [5:0] OP_V4    = 6'd32;
  localparam logic [5:0] OP_V5    = 6'd33;
  localparam logic [5:0] OP_OUT   = 6'd34;

  typedef struct packed {
    logic [5:0] op;
    logic [1:0] idx;
  } owal_cmd_t;

  typedef struct packed {
    logic limited;
    logic cent;
    logic v_zero;
    logic conv_en;
    logic div_done;
    logic sqrt_done;
  } owal_stat_t;

  // divide by 2^sh, round to nearest, ties away from zero
  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] x,
                                                 input logic [5:0] sh);
    logic [63:0] m;
    logic [63:0] q;
    m = x[63] ? 64'(-x) : 64'(x);
    q = (m + (64'd1 << (sh - 6'd1))) >> sh;
    return x[63] ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [63:0] x);
    if (x > 64'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (x < -64'sd8388608) begin
      return 24'sh800000;
    end else begin
      return x[23:0];
    end
  endfunction

endpackage

[src/owal_div.sv]
// Restoring divider, one quotient bit per cycle, rounds to nearest.
// Depends on nothing but its ports.
module owal_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [53:0]  num,
  input  logic        [25:0]  den,
  output logic                done,
  output logic signed [49:0]  quo
);

  logic        busy;
  logic [5:0]  cnt;
  logic        neg;
  logic [48:0] dvd;
  logic [26:0] rem;
  logic [25:0] dreg;
  logic [53:0] num_mag;
  logic [26:0] rem_sh;

  assign num_mag = num[53] ? 54'(-num) : 54'(num);
  assign rem_sh  = {rem[25:0], dvd[48]};
  assign quo     = neg ? -$signed(50'(dvd)) : $signed(50'(dvd));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd48) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= num[53];
      dvd  <= num_mag[48:0] + 49'(den >> 1);
      rem  <= '0;
      dreg <= den;
    end else if (busy) begin
      if (rem_sh >= {1'b0, dreg}) begin
        rem <= rem_sh - {1'b0, dreg};
        dvd <= {dvd[47:0], 1'b1};
      end else begin
        rem <= rem_sh;
        dvd <= {dvd[47:0], 1'b0};
      end
    end
  end

endmodule

[src/owal_sqrt.sv]
// Integer square root (floor), two radicand bits per cycle.
// Depends on nothing but its ports.
module owal_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] x,
  output logic        done,
  output logic [23:0] root
);

  logic        busy;
  logic [4:0]  cnt;
  logic [47:0] xr;
  logic [25:0] rem;
  logic [27:0] rem_sh;
  logic [27:0] trial;

  assign rem_sh = {rem, xr[47:46]};
  assign trial  = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd23) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xr   <= x;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      xr <= {xr[45:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= 26'(rem_sh - trial);
        root <= {root[22:0], 1'b1};
      end else begin
        rem  <= rem_sh[25:0];
        root <= {root[22:0], 1'b0};
      end
    end
  end

endmodule

[src/owal_dp.sv]
// Datapath: config registers, wheel/body registers, shared multiplier,
// divider, square-root and divide-by-2560 units. Depends on owal_pkg, owal_div, owal_sqrt.
module owal_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  owal_pkg::owal_cmd_t    cmd,
  output owal_pkg::owal_stat_t   stat,
  input  logic signed [23:0]     cmd_vx,
  input  logic signed [23:0]     cmd_vy,
  input  logic signed [23:0]     cmd_w,
  output logic signed [23:0]     out_vx,
  output logic signed [23:0]     out_vy,
  output logic signed [23:0]     out_w,
  output logic                   was_limited,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [15:0]            cfg_data
);
  import owal_pkg::*;

  logic [15:0]        thr;
  logic               conv_en;
  logic signed [23:0] vx, vy, w, cx;
  logic signed [24:0] a, b;
  logic signed [45:0] rprod;
  logic signed [53:0] prod;
  logic signed [23:0] ws   [4];
  logic signed [23:0] prev [4];
  logic signed [24:0] acc  [4];
  logic [25:0]        bn;
  logic [17:0]        bd;
  logic [43:0]        p1;
  logic               limited, cent;
  logic [47:0]        s;
  logic [30:0]        rhs;
  logic [23:0]        v, vd;
  logic signed [25:0] sum_r, dx_r, dy_r;

  logic signed [26:0] ma, mb;
  logic               mul_en;
  logic signed [24:0] acc_sel, ab;
  logic signed [23:0] prev_sel;
  logic [24:0]        acc_mag;
  logic [25:0]        nval;
  logic [17:0]        dval;
  logic               up;
  logic [23:0]        wmag;
  logic [23:0]        ws_mag [4];
  logic [23:0]        m01, m23, mall, vmax;
  logic [48:0]        lhs;

  logic               div_start, div_done;
  logic [25:0]        div_den;
  logic signed [49:0] dq;
  logic               sqrt_start, sqrt_done;
  logic [23:0]        h;

  logic               cv_start, cv_busy, cv_done, cv_neg;
  logic [2:0]         cv_cnt;
  logic [53:0]        cv_mag;
  logic [37:0]        cv_y, cv_q, cv_rem;
  logic [3:0]         cv_r;
  logic signed [38:0] cv_quo;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr     <= 16'd2560;
      conv_en <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ACCEL_THR: thr <= cfg_data;
        REG_CONV_EN:   conv_en <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign acc_sel  = acc[cmd.idx];
  assign prev_sel = prev[cmd.idx];
  assign acc_mag  = acc_sel[24] ? 25'(-acc_sel) : 25'(acc_sel);
  assign nval     = {acc_mag, 1'b0};
  // speeding up unless change and stored speed have strictly opposite signs
  assign up = (!acc_sel[24] && !prev_sel[23]) ||
              ((acc_sel[24] || acc_sel == 25'sd0) && (prev_sel[23] || prev_sel == 24'sd0));
  assign dval = up ? {1'b0, thr, 1'b0} : 18'(thr) + {1'b0, thr, 1'b0};
  assign ab   = cmd.idx[0] ? b : a;
  assign wmag = w[23] ? 24'(-w) : 24'(w);
  assign lhs  = {prod[47:0], 1'b0} + 49'(prod[47:0]);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ws_mag[i] = ws[i][23] ? 24'(-ws[i]) : 24'(ws[i]);
    end
    m01  = (ws_mag[1] > ws_mag[0]) ? ws_mag[1] : ws_mag[0];
    m23  = (ws_mag[3] > ws_mag[2]) ? ws_mag[3] : ws_mag[2];
    mall = (m23 > m01) ? m23 : m01;
    vmax = (mall < 24'(thr)) ? 24'(thr) : mall;
  end

  // shared multiplier operand select
  always_comb begin
    ma     = '0;
    mb     = '0;
    mul_en = 1'b1;
    case (cmd.op)
      OP_RMUL: begin ma = 27'(w); mb = K_DIST; end
      OP_WMUL: begin ma = cmd.idx[1] ? -27'(ab) : 27'(ab); mb = K_DIAG; end
      OP_CMP1: begin ma = $signed({1'b0, nval}); mb = $signed({9'd0, bd}); end
      OP_CMP2: begin ma = $signed({1'b0, bn}); mb = $signed({9'd0, dval}); end
      OP_SMUL: begin ma = 27'(acc_sel); mb = $signed({9'd0, bd}); end
      OP_B1:   begin ma = -27'(sum_r); mb = K_INV_W; end
      OP_B2:   begin ma = 27'(dx_r); mb = K_INV_V; end
      OP_B3:   begin ma = 27'(dy_r); mb = K_INV_V; end
      OP_C1:   begin ma = 27'(vx); mb = 27'(vx); end
      OP_C2:   begin ma = 27'(vy); mb = 27'(vy); end
      OP_C4:   begin ma = $signed({3'd0, h}); mb = $signed({3'd0, wmag}); end
      OP_KMUL: begin ma = 27'(ws[cmd.idx]); mb = $signed({3'd0, vd}); end
      OP_V1:   begin ma = 27'(vy); mb = 27'(w); end
      OP_V3:   begin ma = 27'(vx); mb = 27'(w); end
      default: mul_en = 1'b0;
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_den   = '0;
    case (cmd.op)
      OP_SDIV: begin div_start = 1'b1; div_den = bn; end
      OP_KDIV: begin div_start = 1'b1; div_den = {2'b00, v}; end
      default: ;
    endcase
  end

  assign sqrt_start = (cmd.op == OP_SQ);

  owal_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (prod),
    .den   (div_den),
    .done  (div_done),
    .quo   (dq)
  );

  owal_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .x     (s),
    .done  (sqrt_done),
    .root  (h)
  );

  // rounded divide by 2560: shift by 512, then divide by 5 through the
  // 0.8 = 0.75 * (1 + 1/16)(1 + 1/256)... series, fixed up from the remainder
  assign cv_start = (cmd.op == OP_V2) || (cmd.op == OP_V4);
  assign cv_mag   = prod[53] ? 54'(-prod) : 54'(prod);
  assign cv_rem   = cv_y - (cv_q << 2) - cv_q;
  assign cv_quo   = cv_neg ? -$signed({1'b0, cv_q}) : $signed({1'b0, cv_q});

  always_ff @(posedge clk) begin
    if (rst) begin
      cv_busy <= 1'b0;
      cv_done <= 1'b0;
      cv_cnt  <= '0;
    end else begin
      cv_done <= 1'b0;
      if (cv_start) begin
        cv_busy <= 1'b1;
        cv_cnt  <= '0;
      end else if (cv_busy) begin
        cv_cnt <= cv_cnt + 3'd1;
        if (cv_cnt == 3'd7) begin
          cv_busy <= 1'b0;
          cv_done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cv_start) begin
      cv_neg <= prod[53];
      cv_y   <= 38'((cv_mag + 54'(CONV_DIV >> 1)) >> 9);
    end else if (cv_busy) begin
      case (cv_cnt)
        3'd0: cv_q <= (cv_y >> 1) + (cv_y >> 2);
        3'd1: cv_q <= cv_q + (cv_q >> 4);
        3'd2: cv_q <= cv_q + (cv_q >> 8);
        3'd3: cv_q <= cv_q + (cv_q >> 16);
        3'd4: cv_q <= cv_q + (cv_q >> 32);
        3'd5: cv_q <= cv_q >> 2;
        3'd6: cv_r <= cv_rem[3:0];
        // estimate is low by at most two
        default: cv_q <= cv_q + ((cv_r >= 4'd10) ? 38'd2 : (cv_r >= 4'd5) ? 38'd1 : 38'd0);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= ma * mb;
    end
  end

  // control-like flags and stored wheel speeds
  always_ff @(posedge clk) begin
    if (rst) begin
      limited <= 1'b0;
      cent    <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        prev[i] <= '0;
      end
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          limited <= 1'b0;
          cent    <= 1'b0;
        end
        OP_CMP3: if (p1 > prod[43:0]) limited <= 1'b1;
        OP_C5: begin
          if (lhs > 49'(rhs)) begin
            cent    <= 1'b1;
            limited <= 1'b1;
          end
        end
        OP_STORE: begin
          for (int i = 0; i < 4; i++) begin
            prev[i] <= ws[i];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        vx  <= cmd_vx;
        vy  <= cmd_vy;
        w   <= cmd_w;
        a   <= 25'(cmd_vx) - 25'(cmd_vy);
        b   <= 25'(cmd_vx) + 25'(cmd_vy);
        bn  <= 26'd1;
        bd  <= 18'd1;
        rhs <= 31'(thr) * CENT_K;
      end
      // first wheel multiply comes right after the rotation term
      OP_WMUL: if (cmd.idx == 2'd0) rprod <= prod[45:0];
      OP_WFIN: ws[cmd.idx] <= sat24(rnd_shr(64'(prod) - 64'(rprod), SH_WHEEL));
      OP_ACC:  acc[cmd.idx] <= 25'(ws[cmd.idx]) - 25'(prev_sel);
      OP_CMP2: p1 <= prod[43:0];
      OP_CMP3: begin
        if (p1 > prod[43:0]) begin
          bn <= nval;
          bd <= dval;
        end
      end
      OP_SFIN: ws[cmd.idx] <= sat24(64'(prev_sel) + 64'(dq));
      OP_BSUM: begin
        sum_r <= 26'(ws[0]) + 26'(ws[1]) + 26'(ws[2]) + 26'(ws[3]);
        dx_r  <= 26'(ws[0]) + 26'(ws[1]) - 26'(ws[2]) - 26'(ws[3]);
        dy_r  <= 26'(ws[1]) + 26'(ws[2]) - 26'(ws[0]) - 26'(ws[3]);
      end
      OP_B2:   w  <= sat24(rnd_shr(64'(prod), SH_BODY));
      OP_B3:   vx <= sat24(rnd_shr(64'(prod), SH_BODY));
      OP_B4:   vy <= sat24(rnd_shr(64'(prod), SH_BODY));
      OP_C2:   s  <= prod[47:0];
      OP_C3:   s  <= s + prod[47:0];
      OP_C6:   v  <= vmax;
      OP_C7:   vd <= v - 24'(thr);
      OP_KFIN: ws[cmd.idx] <= sat24(64'(dq));
      OP_V3:   cx <= sat24(64'(vx) + 64'(cv_quo));
      OP_V5: begin
        vy <= sat24(64'(vy) - 64'(cv_quo));
        vx <= cx;
      end
      OP_OUT: begin
        out_vx      <= vx;
        out_vy      <= vy;
        out_w       <= w;
        was_limited <= limited;
      end
      default: ;
    endcase
  end

  assign stat.limited   = limited;
  assign stat.cent      = cent;
  assign stat.v_zero    = (v == 24'd0);
  assign stat.conv_en   = conv_en;
  assign stat.div_done  = div_done || cv_done;
  assign stat.sqrt_done = sqrt_done;

endmodule

[src/owal_ctrl.sv]
// Sequencer for the limiter: steps the datapath through wheel mapping,
// limiting, body mapping, centripetal check and correction. Uses owal_pkg.
module owal_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output owal_pkg::owal_cmd_t   cmd,
  input  owal_pkg::owal_stat_t  stat
);
  import owal_pkg::*;
  `include "omni_wheel_accel_limiter_macros.svh"

  localparam logic [5:0] ST_IDLE  = 6'd0;
  localparam logic [5:0] ST_RMUL  = 6'd1;
  localparam logic [5:0] ST_WMUL  = 6'd2;
  localparam logic [5:0] ST_WFIN  = 6'd3;
  localparam logic [5:0] ST_ACC   = 6'd4;
  localparam logic [5:0] ST_CMP1  = 6'd5;
  localparam logic [5:0] ST_CMP2  = 6'd6;
  localparam logic [5:0] ST_CMP3  = 6'd7;
  localparam logic [5:0] ST_LCHK  = 6'd8;
  localparam logic [5:0] ST_SMUL  = 6'd9;
  localparam logic [5:0] ST_SDIV  = 6'd10;
  localparam logic [5:0] ST_SWAIT = 6'd11;
  localparam logic [5:0] ST_SFIN  = 6'd12;
  localparam logic [5:0] ST_BSUM  = 6'd13;
  localparam logic [5:0] ST_B1    = 6'd14;
  localparam logic [5:0] ST_B2    = 6'd15;
  localparam logic [5:0] ST_B3    = 6'd16;
  localparam logic [5:0] ST_B4    = 6'd17;
  localparam logic [5:0] ST_C1    = 6'd18;
  localparam logic [5:0] ST_C2    = 6'd19;
  localparam logic [5:0] ST_C3    = 6'd20;
  localparam logic [5:0] ST_SQ    = 6'd21;
  localparam logic [5:0] ST_SQW   = 6'd22;
  localparam logic [5:0] ST_C4    = 6'd23;
  localparam logic [5:0] ST_C5    = 6'd24;
  localparam logic [5:0] ST_C6    = 6'd25;
  localparam logic [5:0] ST_C7    = 6'd26;
  localparam logic [5:0] ST_KMUL  = 6'd27;
  localparam logic [5:0] ST_KDIV  = 6'd28;
  localparam logic [5:0] ST_KWAIT = 6'd29;
  localparam logic [5:0] ST_KFIN  = 6'd30;
  localparam logic [5:0] ST_STORE = 6'd31;
  localparam logic [5:0] ST_V1    = 6'd32;
  localparam logic [5:0] ST_V2    = 6'd33;
  localparam logic [5:0] ST_V2W   = 6'd34;
  localparam logic [5:0] ST_V3    = 6'd35;
  localparam logic [5:0] ST_V4    = 6'd36;
  localparam logic [5:0] ST_V4W   = 6'd37;
  localparam logic [5:0] ST_V5    = 6'd38;
  localparam logic [5:0] ST_DONE  = 6'd39;

  logic [5:0] state, state_next;
  logic [1:0] idx, idx_next;
  logic       pass2, pass2_next;
  logic       out_load;
  logic       div_wait;

  assign in_ready = (state == ST_IDLE);
  assign out_load = (state == ST_DONE) && (!out_valid || out_ready);
  assign div_wait = (state == ST_SWAIT) || (state == ST_KWAIT) ||
                    (state == ST_V2W) || (state == ST_V4W);

  always_comb begin
    cmd.idx = idx;
    case (state)
      ST_IDLE:  cmd.op = in_valid ? OP_LOAD : OP_NOP;
      ST_RMUL:  cmd.op = OP_RMUL;
      ST_WMUL:  cmd.op = OP_WMUL;
      ST_WFIN:  cmd.op = OP_WFIN;
      ST_ACC:   cmd.op = OP_ACC;
      ST_CMP1:  cmd.op = OP_CMP1;
      ST_CMP2:  cmd.op = OP_CMP2;
      ST_CMP3:  cmd.op = OP_CMP3;
      ST_SMUL:  cmd.op = OP_SMUL;
      ST_SDIV:  cmd.op = OP_SDIV;
      ST_SFIN:  cmd.op = OP_SFIN;
      ST_BSUM:  cmd.op = OP_BSUM;
      ST_B1:    cmd.op = OP_B1;
      ST_B2:    cmd.op = OP_B2;
      ST_B3:    cmd.op = OP_B3;
      ST_B4:    cmd.op = OP_B4;
      ST_C1:    cmd.op = OP_C1;
      ST_C2:    cmd.op = OP_C2;
      ST_C3:    cmd.op = OP_C3;
      ST_SQ:    cmd.op = OP_SQ;
      ST_C4:    cmd.op = OP_C4;
      ST_C5:    cmd.op = OP_C5;
      ST_C6:    cmd.op = OP_C6;
      ST_C7:    cmd.op = OP_C7;
      ST_KMUL:  cmd.op = OP_KMUL;
      ST_KDIV:  cmd.op = OP_KDIV;
      ST_KFIN:  cmd.op = OP_KFIN;
      ST_STORE: cmd.op = OP_STORE;
      ST_V1:    cmd.op = OP_V1;
      ST_V2:    cmd.op = OP_V2;
      ST_V3:    cmd.op = OP_V3;
      ST_V4:    cmd.op = OP_V4;
      ST_V5:    cmd.op = OP_V5;
      ST_DONE:  cmd.op = out_load ? OP_OUT : OP_NOP;
      default:  cmd.op = OP_NOP;
    endcase
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    pass2_next = pass2;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_RMUL;
          idx_next   = 2'd0;
          pass2_next = 1'b0;
        end
      end
      ST_RMUL: state_next = ST_WMUL;
      ST_WMUL: state_next = ST_WFIN;
      ST_WFIN: begin
        idx_next   = idx + 2'd1;
        state_next = (idx == 2'd3) ? ST_ACC : ST_WMUL;
      end
      ST_ACC:  state_next = ST_CMP1;
      ST_CMP1: state_next = ST_CMP2;
      ST_CMP2: state_next = ST_CMP3;
      ST_CMP3: begin
        idx_next   = idx + 2'd1;
        state_next = (idx == 2'd3) ? ST_LCHK : ST_ACC;
      end
      ST_LCHK:  state_next = stat.limited ? ST_SMUL : ST_BSUM;
      ST_SMUL:  state_next = ST_SDIV;
      ST_SDIV:  state_next = ST_SWAIT;
      ST_SWAIT: if (stat.div_done) state_next = ST_SFIN;
      ST_SFIN: begin
        idx_next   = idx + 2'd1;
        state_next = (idx == 2'd3) ? ST_BSUM : ST_SMUL;
      end
      ST_BSUM: state_next = ST_B1;
      ST_B1:   state_next = ST_B2;
      ST_B2:   state_next = ST_B3;
      ST_B3:   state_next = ST_B4;
      ST_B4:   state_next = pass2 ? ST_STORE : ST_C1;
      ST_C1:   state_next = ST_C2;
      ST_C2:   state_next = ST_C3;
      ST_C3:   state_next = ST_SQ;
      ST_SQ:   state_next = ST_SQW;
      ST_SQW:  if (stat.sqrt_done) state_next = ST_C4;
      ST_C4:   state_next = ST_C5;
      ST_C5:   state_next = ST_C6;
      ST_C6:   state_next = stat.cent ? ST_C7 : ST_STORE;
      ST_C7: begin
        pass2_next = 1'b1;
        state_next = stat.v_zero ? ST_BSUM : ST_KMUL;
      end
      ST_KMUL:  state_next = ST_KDIV;
      ST_KDIV:  state_next = ST_KWAIT;
      ST_KWAIT: if (stat.div_done) state_next = ST_KFIN;
      ST_KFIN: begin
        idx_next   = idx + 2'd1;
        state_next = (idx == 2'd3) ? ST_BSUM : ST_KMUL;
      end
      ST_STORE: state_next = stat.conv_en ? ST_V1 : ST_DONE;
      ST_V1:    state_next = ST_V2;
      ST_V2:    state_next = ST_V2W;
      ST_V2W:   if (stat.div_done) state_next = ST_V3;
      ST_V3:    state_next = ST_V4;
      ST_V4:    state_next = ST_V4W;
      ST_V4W:   if (stat.div_done) state_next = ST_V5;
      ST_V5:    state_next = ST_DONE;
      ST_DONE:  if (out_load) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx       <= '0;
      pass2     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      pass2 <= pass2_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `OWAL_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  `OWAL_ASSERT_SAME(a_div_done_waiting, clk, rst, stat.div_done, div_wait)
  `OWAL_ASSERT_SAME(a_sqrt_done_waiting, clk, rst, stat.sqrt_done, state == ST_SQW)

endmodule

[src/omni_wheel_accel_limiter.sv]
// Top level of the omni-wheel acceleration limiter.
// Depends on owal_pkg, owal_ctrl and owal_dp.
//
//   channel  handshake              payload
//   in       in_valid / in_ready    cmd_vx, cmd_vy, cmd_w
//   out      out_valid / out_ready  out_vx, out_vy, out_w, was_limited
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An item's time from accept to result grows with the active steps; the shared
// divider (four scaling divisions in the limit step, four in the centripetal
// correction) and the root set this. The convection correction adds two
// divides by 2560.
// Active-high sync reset clears stored wheel speeds, conv_en; thr to 2560.
// A new item is taken while the previous result waits in the output register.
// cfg_ready is always high.
module omni_wheel_accel_limiter (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [23:0] cmd_vx,
  input  logic signed [23:0] cmd_vy,
  input  logic signed [23:0] cmd_w,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [23:0] out_vx,
  output logic signed [23:0] out_vy,
  output logic signed [23:0] out_w,
  output logic               was_limited,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import owal_pkg::*;

  owal_cmd_t  cmd;
  owal_stat_t stat;

  owal_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  owal_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cmd_vx      (cmd_vx),
    .cmd_vy      (cmd_vy),
    .cmd_w       (cmd_w),
    .out_vx      (out_vx),
    .out_vy      (out_vy),
    .out_w       (out_w),
    .was_limited (was_limited),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

endmodule

[test/tb_top.sv]
// Self-checking testbench for omni_wheel_accel_limiter: directed table, then random
// phases over several threshold/convection settings, checked by a cycle-free predictor.
// Depends on owal_pkg (register indexes) and the limiter RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import owal_pkg::*;

  localparam logic [1:0] REG_SPARE_A = 2'd2;
  localparam logic [1:0] REG_SPARE_B = 2'd3;
  localparam longint DIAG_Q16  = 46334;
  localparam longint DIST_Q16  = 1330381;
  localparam longint INV_W_Q24 = 206616;
  localparam longint INV_V_Q24 = 5932537;
  localparam longint CENT_SCALE = 25600;
  localparam longint CONV_SCALE = 2560;
  localparam logic signed [23:0] MAX24 = 24'sh7FFFFF;
  localparam logic signed [23:0] MIN24 = 24'sh800000;
  localparam int CYCLE_LIMIT = 6000000;
  localparam int N_PHASES = 8;
  localparam int PHASE_ITEMS = 168;

  typedef struct {
    logic signed [23:0] vx;
    logic signed [23:0] vy;
    logic signed [23:0] w;
    logic               lim;
  } motion_t;

  typedef struct {
    logic signed [23:0] vx;
    logic signed [23:0] vy;
    logic signed [23:0] w;
    bit                 typed;
    motion_t            exp;
  } stim_row_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0, in_ready;
  logic signed [23:0] cmd_vx = 0, cmd_vy = 0, cmd_w = 0;
  logic out_valid, out_ready = 0;
  logic signed [23:0] out_vx, out_vy, out_w;
  logic was_limited;
  logic cfg_valid = 0, cfg_ready;
  logic [1:0] cfg_index = 0;
  logic [15:0] cfg_data = 0;

  omni_wheel_accel_limiter dut (.*);

  always #4 clk = ~clk;

  // predictor state and config
  longint stored_wheel [4];
  longint thr_q8;
  bit conv_on;

  motion_t expected_motion [$];
  int n_sent, n_checked, n_limited, n_errors;
  longint cycles;

  function automatic longint sat24l(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic longint rdiv(longint num, longint den);
    longint m, q;
    m = num < 0 ? -num : num;
    q = (m + den / 2) / den;
    return num < 0 ? -q : q;
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint isqrt(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic void wheels_to_body(input longint ws [4], output longint vx,
                                         output longint vy, output longint w);
    longint sum, dx, dy;
    sum = ws[0] + ws[1] + ws[2] + ws[3];
    dx = ws[0] + ws[1] - ws[2] - ws[3];
    dy = ws[1] + ws[2] - ws[0] - ws[3];
    w  = sat24l(rdiv(-sum * INV_W_Q24, 64'sd1 << 24));
    vx = sat24l(rdiv(dx * INV_V_Q24, 64'sd1 << 24));
    vy = sat24l(rdiv(dy * INV_V_Q24, 64'sd1 << 24));
  endfunction

  // full limiter step; updates stored_wheel
  function automatic motion_t limit_motion(logic signed [23:0] cx, logic signed [23:0] cy,
                                           logic signed [23:0] cw);
    longint vx, vy, w, a, b, r, bn, bd, n, d, old, v, ox, lhs, rhs;
    longint ws [4];
    longint acc [4];
    bit lim, up;
    motion_t res;
    vx = cx; vy = cy; w = cw;
    a = vx - vy; b = vx + vy; r = w * DIST_Q16;
    ws[0] = sat24l(rdiv(a * DIAG_Q16 - r, 65536));
    ws[1] = sat24l(rdiv(b * DIAG_Q16 - r, 65536));
    ws[2] = sat24l(rdiv(-a * DIAG_Q16 - r, 65536));
    ws[3] = sat24l(rdiv(-b * DIAG_Q16 - r, 65536));
    bn = 1; bd = 1; lim = 0;
    for (int i = 0; i < 4; i++) begin
      old = stored_wheel[i];
      acc[i] = ws[i] - old;
      up = (acc[i] >= 0 && old >= 0) || (acc[i] <= 0 && old <= 0);
      d = up ? 2 * thr_q8 : 3 * thr_q8;
      n = 2 * mag(acc[i]);
      if (n * bd > bn * d) begin
        bn = n; bd = d; lim = 1;
      end
    end
    if (lim)
      for (int i = 0; i < 4; i++) ws[i] = sat24l(stored_wheel[i] + rdiv(acc[i] * bd, bn));
    wheels_to_body(ws, vx, vy, w);
    lhs = 3 * isqrt(vx * vx + vy * vy) * mag(w);
    rhs = CENT_SCALE * thr_q8;
    if (lhs > rhs) begin
      lim = 1;
      v = 0;
      for (int i = 0; i < 4; i++) if (mag(ws[i]) > v) v = mag(ws[i]);
      if (v < thr_q8) v = thr_q8;
      if (v > 0)
        for (int i = 0; i < 4; i++) ws[i] = sat24l(rdiv(ws[i] * (v - thr_q8), v));
      wheels_to_body(ws, vx, vy, w);
    end
    for (int i = 0; i < 4; i++) stored_wheel[i] = ws[i];
    // rotation correction uses the uncorrected vx
    if (conv_on) begin
      ox = vx;
      vx = sat24l(vx + rdiv(vy * w, CONV_SCALE));
      vy = sat24l(vy - rdiv(ox * w, CONV_SCALE));
    end
    res.vx = vx; res.vy = vy; res.w = w; res.lim = lim;
    return res;
  endfunction

  function automatic logic signed [23:0] edge_value();
    case ($urandom_range(0, 4))
      0: return MAX24;
      1: return MIN24;
      2: return 24'sd0;
      3: return -24'sd1;
      default: return 24'sd1;
    endcase
  endfunction

  function automatic logic signed [23:0] near(logic signed [23:0] base, int span);
    return base + 24'($urandom_range(0, 2 * span)) - 24'(span);
  endfunction

  function automatic bit calm_window();
    return n_sent >= 700 && n_sent < 900;
  endfunction

  task automatic send_cmd(logic signed [23:0] vx, logic signed [23:0] vy,
                          logic signed [23:0] w, bit typed, motion_t exp);
    motion_t p;
    while (!calm_window() && $urandom_range(0, 99) < 13) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    cmd_vx <= vx; cmd_vy <= vy; cmd_w <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    p = limit_motion(vx, vy, w);
    expected_motion.push_back(typed ? exp : p);
    n_sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (expected_motion.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    if (idx == REG_ACCEL_THR) thr_q8 = data;
    else if (idx == REG_CONV_EN) conv_on = data[0];
    @(posedge clk);
  endtask

  // output side: random stalls, one long hold-off, a calm stretch
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 0;
      end else if (!hold_done && n_sent >= 400) begin
        hold_left = 3000;
        hold_done = 1;
        out_ready <= 0;
      end else begin
        out_ready <= calm_window() ? 1'b1 : ($urandom_range(0, 99) >= 13);
      end
    end
  end

  always @(posedge clk) begin
    motion_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_motion.size() == 0) begin
        $error("result beat with nothing expected");
        n_errors++;
      end else begin
        e = expected_motion.pop_front();
        n_checked++;
        if (e.lim) n_limited++;
        if (out_vx !== e.vx) begin
          $error("out_vx expected %0d got %0d", e.vx, out_vx); n_errors++;
        end
        if (out_vy !== e.vy) begin
          $error("out_vy expected %0d got %0d", e.vy, out_vy); n_errors++;
        end
        if (out_w !== e.w) begin
          $error("out_w expected %0d got %0d", e.w, out_w); n_errors++;
        end
        if (was_limited !== e.lim) begin
          $error("was_limited expected %0b got %0b", e.lim, was_limited); n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    stim_row_t rows [$];
    stim_row_t row;
    motion_t none, zero_out;
    logic signed [23:0] lx, ly, lw, vx, vy, w;
    logic [15:0] phase_thr [N_PHASES];
    bit phase_conv [N_PHASES];
    int mode;

    cycles = 0; n_sent = 0; n_checked = 0; n_limited = 0; n_errors = 0;
    thr_q8 = 2560; conv_on = 0;
    for (int i = 0; i < 4; i++) stored_wheel[i] = 0;
    none = '{0, 0, 0, 0};
    zero_out = '{0, 0, 0, 0};

    // directed rows: extremes of each field, sharp reversals, rotation with speed
    rows.push_back('{24'sd0, 24'sd0, 24'sd0, 1, zero_out});
    rows.push_back('{24'sd0, 24'sd0, 24'sd0, 1, zero_out});
    rows.push_back('{24'sd256, 24'sd0, 24'sd0, 0, none});
    rows.push_back('{MAX24, 24'sd0, 24'sd0, 0, none});
    rows.push_back('{MIN24, 24'sd0, 24'sd0, 0, none});
    rows.push_back('{24'sd0, MAX24, 24'sd0, 0, none});
    rows.push_back('{24'sd0, MIN24, 24'sd0, 0, none});
    rows.push_back('{24'sd0, 24'sd0, MAX24, 0, none});
    rows.push_back('{24'sd0, 24'sd0, MIN24, 0, none});
    rows.push_back('{MAX24, MAX24, MAX24, 0, none});
    rows.push_back('{MIN24, MIN24, MIN24, 0, none});
    rows.push_back('{MAX24, MIN24, 24'sd0, 0, none});
    rows.push_back('{24'sd0, 24'sd0, 24'sd0, 0, none});
    rows.push_back('{24'sd400000, 24'sd300000, 24'sd2000, 0, none});
    rows.push_back('{-24'sd1, -24'sd1, -24'sd1, 0, none});
    rows.push_back('{24'sd1, 24'sd1, 24'sd1, 0, none});

    phase_thr = '{16'd1, 16'd65535, 16'd0, 16'd300, 16'd2560, 16'd12000, 16'd40,
                  16'($urandom_range(1, 65535))};
    phase_conv = '{0, 1, 1, 0, 1, 0, 1, 1'($urandom_range(0, 1))};

    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (rows[i]) begin
      row = rows[i];
      send_cmd(row.vx, row.vy, row.w, row.typed, row.exp);
    end
    drain();

    lx = 0; ly = 0; lw = 0;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      // unused indexes must not disturb the live registers
      write_reg(REG_SPARE_A, 16'($urandom));
      write_reg(REG_ACCEL_THR, phase_thr[ph]);
      write_reg(REG_CONV_EN, {15'($urandom), phase_conv[ph]});
      write_reg(REG_SPARE_B, 16'($urandom));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        mode = $urandom_range(0, 99);
        if (mode < 35) begin
          vx = near(0, 4096); vy = near(0, 4096); w = near(0, 64);
        end else if (mode < 60) begin
          vx = near(lx, 1024); vy = near(ly, 1024); w = near(lw, 16);
        end else if (mode < 75) begin
          vx = 24'($urandom); vy = 24'($urandom); w = 24'($urandom);
        end else if (mode < 85) begin
          vx = edge_value(); vy = edge_value(); w = edge_value();
        end else begin
          vx = near(0, 65536); vy = near(0, 65536); w = near(0, 4096);
        end
        send_cmd(vx, vy, w, 0, none);
        lx = vx; ly = vy; lw = w;
      end
      drain();
    end

    repeat (600) @(posedge clk);
    $display("checked %0d results (%0d limited) over %0d threshold settings",
             n_checked, n_limited, N_PHASES + 1);
    $display("convection on and off, extremes, zero threshold, unused register writes");
    if (n_errors == 0 && expected_motion.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
